### rtl/core/pr_pkg.sv
// ============================================================================
// pr_pkg: shared types and constants for the PageRank iteration block
// Fixed-point widths, beat structures and saturation helpers.
// ============================================================================
package pr_pkg;

    // Problem size and fixed-point format.
    localparam int NODES     = 4;
    localparam int FRAC_BITS = 15;

    // Field widths of the command and result beats.
    localparam int OP_W    = 1;
    localparam int POS_W   = 2;
    localparam int ENTRY_W = 16;
    localparam int ITER_W  = 8;
    localparam int RANK_W  = 16;
    localparam int ALPHA_W = 16;

    // Internal widths.
    localparam int NODE_W  = $clog2(NODES);
    localparam int MAT_AW  = $clog2(NODES * NODES);
    localparam int ONE_W   = FRAC_BITS + 1;
    localparam int D_W     = FRAC_BITS + 2;
    localparam int V_W     = FRAC_BITS + 3;
    localparam int PROD_W  = D_W + V_W;
    localparam int ACC_W   = PROD_W + NODE_W;
    localparam int Y_W     = ACC_W + 1 - FRAC_BITS;
    localparam int S_W     = Y_W + NODE_W;
    localparam int Q_W     = ONE_W;
    localparam int NUM_W   = ((Y_W + FRAC_BITS) > S_W ? (Y_W + FRAC_BITS) : S_W) + 1;
    localparam int ECMP_W  = ENTRY_W > ONE_W ? ENTRY_W : ONE_W;
    localparam int ACMP_W  = ALPHA_W > ONE_W ? ALPHA_W : ONE_W;

    localparam logic [ONE_W-1:0]     ONE  = ONE_W'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(3277);

    // Command operation codes.
    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_RUN  = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [ENTRY_W-1:0] entry_value;
        logic [ITER_W-1:0]  iterations;
    } pr_in_t;

    typedef struct packed {
        logic [POS_W-1:0]  node_index;
        logic [RANK_W-1:0] rank;
        logic              last;
        logic              zero_sum;
    } pr_out_t;

    // Clamp a loaded link weight to 1.0.
    function automatic logic [ONE_W-1:0] sat_entry(input logic [ENTRY_W-1:0] val);
        logic [ONE_W-1:0] res;
        if (ECMP_W'(val) > ECMP_W'(ONE))
            res = ONE;
        else
            res = ONE_W'(val);
        return res;
    endfunction

    // Clamp the damping weight to 1.0.
    function automatic logic [ONE_W-1:0] sat_alpha(input logic [ALPHA_W-1:0] val);
        logic [ONE_W-1:0] res;
        if (ACMP_W'(val) > ACMP_W'(ONE))
            res = ONE;
        else
            res = ONE_W'(val);
        return res;
    endfunction

endpackage

### rtl/core/pr_div.sv
// ============================================================================
// pr_div: restoring divider for rank normalization
// Produces one quotient bit per cycle; the quotient must fit in Q_W bits.
// ============================================================================
module pr_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [pr_pkg::NUM_W-1:0] numerator,
    input  logic [pr_pkg::S_W-1:0]   divisor,
    output logic                     done,
    output logic [pr_pkg::Q_W-1:0]   quotient
);
    import pr_pkg::*;

    localparam int CNT_W = $clog2(Q_W + 1);

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

    div_state_t        state_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [S_W-1:0]    rem_reg;
    logic [S_W-1:0]    den_reg;
    logic [Q_W-1:0]    low_reg;
    logic [Q_W-1:0]    q_reg;

    logic [S_W:0]      trial;
    logic              fits;
    logic [S_W:0]      diff;
    logic [S_W-1:0]    rem_next;

    // One shift-and-subtract step.
    always_comb
    begin
        trial    = {rem_reg, low_reg[Q_W-1]};
        fits     = trial >= {1'b0, den_reg};
        diff     = trial - {1'b0, den_reg};
        rem_next = fits ? diff[S_W-1:0] : trial[S_W-1:0];
    end

    // Sequencer: load, then Q_W steps, then a done strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                DIV_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg   <= CNT_W'(Q_W);
                        state_reg <= DIV_RUN;
                    end
                end
                DIV_RUN:
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= DIV_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= DIV_IDLE;
                end
            endcase
        end
    end

    // Datapath registers. The upper part of the numerator is already below
    // the divisor because the quotient fits in Q_W bits.
    always_ff @(posedge clk)
    begin
        if (state_reg == DIV_IDLE && start)
        begin
            rem_reg <= S_W'(numerator >> Q_W);
            low_reg <= numerator[Q_W-1:0];
            den_reg <= divisor;
            q_reg   <= '0;
        end
        else if (state_reg == DIV_RUN)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[Q_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### rtl/core/pagerank_power_iteration.sv
// ============================================================================
// pagerank_power_iteration: PageRank power iteration on a small link matrix
// Loads matrix entries, then runs damped, L1-normalized iteration rounds.
// ============================================================================
// Usage:
// A command beat is taken at a clock edge with start high and busy low.
// A load beat (operation 0) writes one matrix entry, so loads can follow
// each other every cycle while the block is idle. A run beat (operation 1)
// raises busy while it iterates and while it issues the ranks on result,
// one beat per cycle, each marked by a one-cycle result_valid, the final
// beat with last set. The receiver cannot stall the results.
// Each round steps through a damping multiply, a damping add, a vector
// multiply and an accumulate for every matrix entry on the single shared
// multiplier, closes each row, checks the sum once and then runs the
// bit-serial divider once per node. A round whose sum is zero skips the
// divider.
// The damping register is written through cfg_valid/cfg_ready while the
// block is idle. Reset clears the matrix to zero and sets alpha to 3277.
// ============================================================================
module pagerank_power_iteration (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  pr_pkg::pr_in_t             cmd,
    output logic                       result_valid,
    output pr_pkg::pr_out_t            result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pr_pkg::ALPHA_W-1:0] cfg_data
);
    import pr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_D,
        S_ADD_D,
        S_MUL_V,
        S_ACC,
        S_ROW_END,
        S_CHECK,
        S_DIV_START,
        S_DIV_WAIT,
        S_NEXT,
        S_EMIT
    } state_t;

    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

    state_t              state_reg;
    logic [NODE_W-1:0]   i_reg;
    logic [NODE_W-1:0]   j_reg;
    logic [ITER_W-1:0]   iter_reg;
    logic                zero_reg;
    logic                result_valid_reg;
    pr_out_t             result_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [D_W-1:0]      d_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [S_W-1:0]      s_reg;
    logic [Y_W-1:0]      y_reg [NODES];
    logic [V_W-1:0]      v_reg [NODES];
    logic [ONE_W-1:0]    mat_reg [NODES*NODES];
    logic [ALPHA_W-1:0]  alpha_reg;

    logic                accept;
    logic [MAT_AW-1:0]   load_idx;
    logic [MAT_AW-1:0]   mat_idx;
    logic [ONE_W-1:0]    alpha_sat;
    logic [ONE_W-1:0]    one_minus_a;
    logic [ONE_W-1:0]    tele;
    logic [D_W-1:0]      mul_a;
    logic [V_W-1:0]      mul_b;
    logic [PROD_W-1:0]   mul_result;
    logic [D_W-1:0]      d_next;
    logic [Y_W-1:0]      y_next;
    logic [ONE_W-1:0]    v_sat;
    logic [NUM_W-1:0]    div_num;
    logic                div_start;
    logic                div_done;
    logic [Q_W-1:0]      div_q;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign accept    = start && !busy;

    // Damping terms shared by every matrix entry.
    always_comb
    begin
        alpha_sat   = sat_alpha(alpha_reg);
        one_minus_a = ONE - alpha_sat;
        tele        = ONE_W'(({1'b0, alpha_sat} + (ONE_W + 1)'(NODES / 2)) / NODES);
    end

    // Shared multiplier: first the damping product, then the vector product.
    always_comb
    begin
        mat_idx = MAT_AW'(int'(i_reg) * NODES + int'(j_reg));
        if (state_reg == S_MUL_V)
        begin
            mul_a = d_reg;
            mul_b = v_reg[j_reg];
        end
        else
        begin
            mul_a = D_W'(one_minus_a);
            mul_b = V_W'(mat_reg[mat_idx]);
        end
        mul_result = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Rounding of the damped entry and of the row sum.
    always_comb
    begin
        d_next = D_W'((prod_reg + PROD_W'(HALF)) >> FRAC_BITS) + D_W'(tele);
        y_next = Y_W'(({1'b0, acc_reg} + (ACC_W + 1)'(HALF)) >> FRAC_BITS);
        v_sat  = (v_reg[i_reg] > V_W'(ONE)) ? ONE : ONE_W'(v_reg[i_reg]);
    end

    // Normalization divide: (y * ONE + s/2) / s.
    assign div_num   = (NUM_W'(y_reg[i_reg]) << FRAC_BITS) + NUM_W'(s_reg >> 1);
    assign div_start = (state_reg == S_DIV_START);

    pr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (div_num),
        .divisor   (s_reg),
        .done      (div_done),
        .quotient  (div_q)
    );

    // Damping weight register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alpha_reg <= ALPHA_RESET;
        else if (cfg_valid && cfg_ready)
            alpha_reg <= cfg_data;
    end

    // Link matrix store, written by load beats.
    assign load_idx = MAT_AW'(int'(cmd.row) * NODES + int'(cmd.col));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NODES * NODES; k++)
                mat_reg[k] <= '0;
        end
        else if (accept && cmd.operation == OP_LOAD &&
                 int'(cmd.row) < NODES && int'(cmd.col) < NODES)
        begin
            mat_reg[load_idx] <= sat_entry(cmd.entry_value);
        end
    end

    // Iteration sequencer with its datapath and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            i_reg            <= '0;
            j_reg            <= '0;
            iter_reg         <= '0;
            zero_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            prod_reg         <= '0;
            d_reg            <= '0;
            acc_reg          <= '0;
            s_reg            <= '0;
            for (int k = 0; k < NODES; k++)
            begin
                y_reg[k] <= '0;
                v_reg[k] <= '0;
            end
        end
        else
        begin
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && cmd.operation == OP_RUN)
                    begin
                        for (int k = 0; k < NODES; k++)
                            v_reg[k] <= V_W'(ONE);
                        zero_reg  <= 1'b0;
                        iter_reg  <= cmd.iterations;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        acc_reg   <= '0;
                        s_reg     <= '0;
                        state_reg <= (cmd.iterations == '0) ? S_EMIT : S_MUL_D;
                    end
                end
                S_MUL_D:
                begin
                    prod_reg  <= mul_result;
                    state_reg <= S_ADD_D;
                end
                S_ADD_D:
                begin
                    d_reg     <= d_next;
                    state_reg <= S_MUL_V;
                end
                S_MUL_V:
                begin
                    prod_reg  <= mul_result;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                    if (j_reg == LAST_NODE)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_ROW_END;
                    end
                    else
                    begin
                        j_reg     <= j_reg + NODE_W'(1);
                        state_reg <= S_MUL_D;
                    end
                end
                S_ROW_END:
                begin
                    y_reg[i_reg] <= y_next;
                    s_reg        <= s_reg + S_W'(y_next);
                    acc_reg      <= '0;
                    if (i_reg == LAST_NODE)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        i_reg     <= i_reg + NODE_W'(1);
                        state_reg <= S_MUL_D;
                    end
                end
                S_CHECK:
                begin
                    // An all-zero product cannot be normalized.
                    if (s_reg == '0)
                    begin
                        zero_reg <= 1'b1;
                        for (int k = 0; k < NODES; k++)
                            v_reg[k] <= '0;
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        state_reg <= S_DIV_START;
                    end
                end
                S_DIV_START:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        v_reg[i_reg] <= V_W'(div_q);
                        if (i_reg == LAST_NODE)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            i_reg     <= i_reg + NODE_W'(1);
                            state_reg <= S_DIV_START;
                        end
                    end
                end
                S_NEXT:
                begin
                    i_reg   <= '0;
                    j_reg   <= '0;
                    acc_reg <= '0;
                    s_reg   <= '0;
                    if (iter_reg == ITER_W'(1))
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        iter_reg  <= iter_reg - ITER_W'(1);
                        state_reg <= S_MUL_D;
                    end
                end
                S_EMIT:
                begin
                    result_valid_reg      <= 1'b1;
                    result_reg.node_index <= POS_W'(i_reg);
                    result_reg.rank       <= RANK_W'(v_sat);
                    result_reg.last       <= (i_reg == LAST_NODE);
                    result_reg.zero_sum   <= zero_reg;
                    if (i_reg == LAST_NODE)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        i_reg <= i_reg + NODE_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A result beat only follows an emit cycle.
    ap_beat_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $past(state_reg) == S_EMIT)
        else $error("result beat without an emit cycle");

    // The last flag marks the highest node only.
    ap_last_node: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.last |->
            result_reg.node_index == POS_W'(NODES - 1))
        else $error("last flag on a node other than the final one");

    // The divider reports completion only while the sequencer waits for it.
    ap_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV_WAIT)
        else $error("divider done outside the wait state");

    // A zero sum over all rows sets the zero-sum flag.
    ap_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK && s_reg == '0 |=> zero_reg)
        else $error("zero sum not flagged");

endmodule
